// File: sv/exp_range_reduced_taylor_unit_defines.svh
// assertion macros used by the exponential unit port checker
`ifndef EXP_RANGE_REDUCED_TAYLOR_UNIT_DEFINES_SVH
`define EXP_RANGE_REDUCED_TAYLOR_UNIT_DEFINES_SVH

// clocked assertion, masked while reset is asserted
`define ERAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ERAT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/erat_pkg.sv
// types and constants of the range-reduced exponential unit
package erat_pkg;

    // ln2 as unsigned q0.64 and q2.62, 1/ln2 as unsigned q1.63
    localparam logic [63:0] LN2_Q64    = 64'hB17217F7D1CF79AC;
    localparam logic [63:0] LN2_Q62    = 64'h2C5C85FDF473DE6B;
    localparam logic [63:0] INVLN2_Q63 = 64'hB8AA3B295C17F0BC;

    localparam int unsigned ARG_W   = 48;
    localparam int unsigned MANT_W  = 33;
    localparam int unsigned EXP_W   = 16;
    localparam int unsigned SCALE_W = 14;
    localparam logic [SCALE_W-1:0] SCALE_RST = 14'd16383;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    // state of one item inside the series pipeline
    typedef struct packed {
        logic [63:0]      sum;
        logic [62:0]      tm;
        logic [61:0]      rmag;
        logic             rneg;
        logic [EXP_W-1:0] expo;
        status_t          st;
        logic [3:0][63:0] pp;
        logic [61:0]      a;
    } term_t;

endpackage

// File: sv/exp_range_reduced_taylor_unit.sv
// range-reduced exponential: e^x as mantissa * 2^exponent, fully pipelined
//
//  channel  | dir | handshake          | payload
//  s_axis   | in  | tvalid / tready    | tdata[47:0] arg_value
//  m_axis   | out | tvalid / tready    | tdata[32:0] mantissa, [48:33] exponent; tuser status
//  cfg      | in  | valid / ready      | data[13:0] max_scale
//
// one request per cycle while the skid register is empty; each series term has
// four stages (two split multiplies and their sums)
// reset clears all valid bits and loads max_scale with 16383
// a stalled output parks one result in a skid register, then the whole pipe holds
module exp_range_reduced_taylor_unit
    import erat_pkg::*;
#(
    parameter int TERMS     = 16,
    parameter int FRAC_BITS = 32
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [ARG_W-1:0]    s_axis_tdata,   // [47:0] arg_value
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [55:0]         m_axis_tdata,   // [32:0] mantissa, [48:33] exponent, [55:49] zero
    output logic [1:0]          m_axis_tuser,   // [1:0] status
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SCALE_W-1:0]  cfg_data        // [13:0] max_scale
);

    localparam int NF = 8;
    localparam int NT = 4 * (TERMS - 1) + 1;
    localparam int NS = NF + NT;

    // series step helpers
    function automatic term_t f_acc(term_t t, logic odd);
        term_t r;
        r = t;
        if (t.rneg && odd)
            r.sum = t.sum - 64'(t.tm);
        else
            r.sum = t.sum + 64'(t.tm);
        return r;
    endfunction

    function automatic term_t f_mul_r(term_t t);
        term_t r;
        r = t;
        r.pp[0] = 64'(t.tm[31:0])  * 64'(t.rmag[31:0]);
        r.pp[1] = 64'(t.tm[31:0])  * 64'(t.rmag[61:32]);
        r.pp[2] = 64'(t.tm[62:32]) * 64'(t.rmag[31:0]);
        r.pp[3] = 64'(t.tm[62:32]) * 64'(t.rmag[61:32]);
        return r;
    endfunction

    function automatic logic [127:0] f_comb(term_t t);
        return 128'(t.pp[0]) + (128'(t.pp[1]) << 32) + (128'(t.pp[2]) << 32)
             + (128'(t.pp[3]) << 64);
    endfunction

    function automatic term_t f_sum_r(term_t t);
        term_t        r;
        logic [127:0] p;
        r = t;
        p = f_comb(t);
        r.a = p[123:62];
        return r;
    endfunction

    function automatic term_t f_mul_m(term_t t, logic [63:0] m);
        term_t r;
        r = t;
        r.pp[0] = 64'(t.a[31:0])  * 64'(m[31:0]);
        r.pp[1] = 64'(t.a[31:0])  * 64'(m[63:32]);
        r.pp[2] = 64'(t.a[61:32]) * 64'(m[31:0]);
        r.pp[3] = 64'(t.a[61:32]) * 64'(m[63:32]);
        return r;
    endfunction

    function automatic term_t f_quot(term_t t, int unsigned sh);
        term_t        r;
        logic [127:0] s;
        r = t;
        s = f_comb(t);
        r.tm = 63'(s >> sh);
        return r;
    endfunction

    logic [SCALE_W-1:0] max_scale_reg;
    logic [NS-1:0]      v_reg;
    logic               en;

    // front stage payload
    logic [ARG_W-1:0] s0_raw, s1_raw, s2_raw;
    logic             s0_neg, s1_neg, s2_neg, s3_neg, s4_neg, s5_neg;
    logic [ARG_W-1:0] s0_mag, s1_mag;
    logic [45:0]      s0_pl, s0_ph;
    logic [77:0]      s1_p;
    logic [3:0][55:0] s1_pp;
    logic [111:0]     s2_prod;
    status_t          s2_st, s3_st, s4_st, s5_st, s6_st, s7_st;
    logic [15:0]      s3_kmag;
    logic [63:0]      s3_base, s4_base, s5_base;
    logic [EXP_W-1:0] s4_expo, s5_expo, s6_expo, s7_expo;
    logic [47:0]      s4_ktl, s4_kth;
    logic [63:0]      s5_kterm, s6_rraw;
    logic             s7_rneg;
    logic [61:0]      s7_rmag;

    // combinational front values
    logic [ARG_W-1:0] mag_c;
    logic [63:0]      lmax_c, lmin_c;
    logic [48:0]      kround_c;
    logic [63:0]      kterm_c;

    term_t tp_reg  [NT];
    term_t tp_next [NT];
    term_t t_init;

    // output register and skid
    logic        out_v_reg, skid_v_reg;
    logic [55:0] out_d_reg, skid_d_reg;
    logic [1:0]  out_u_reg, skid_u_reg;
    logic [55:0] res_d;
    logic [63:0] rnd_c;
    logic        push, out_take;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_scale_reg <= SCALE_RST;
        else if (cfg_valid)
            max_scale_reg <= cfg_data;
    end

    // global advance: hold only while a result sits in the skid
    assign en            = !skid_v_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], s_axis_tvalid};
    end

    // front combinational pieces
    assign mag_c    = s_axis_tdata[ARG_W-1] ? (ARG_W'(0) - s_axis_tdata) : s_axis_tdata;
    assign lmax_c   = 64'(s1_p >> (64 - FRAC_BITS));
    assign lmin_c   = 64'(s1_p >> (63 - FRAC_BITS));
    assign kround_c = 49'(s2_prod[111:64]) + (49'd1 << (FRAC_BITS - 2));
    assign kterm_c  = 64'(s4_ktl) + (64'(s4_kth) << 32);

    // front stages: limits, k, remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // negate argument, limit partial products
            s0_raw <= s_axis_tdata;
            s0_neg <= s_axis_tdata[ARG_W-1];
            s0_mag <= mag_c;
            s0_pl  <= 46'(max_scale_reg) * 46'(LN2_Q64[31:0]);
            s0_ph  <= 46'(max_scale_reg) * 46'(LN2_Q64[63:32]);
            // limit product, |x| * 1/ln2 partials
            s1_raw   <= s0_raw;
            s1_neg   <= s0_neg;
            s1_mag   <= s0_mag;
            s1_p     <= (78'(s0_ph) << 32) + 78'(s0_pl);
            s1_pp[0] <= 56'(s0_mag[23:0])  * 56'(INVLN2_Q63[31:0]);
            s1_pp[1] <= 56'(s0_mag[23:0])  * 56'(INVLN2_Q63[63:32]);
            s1_pp[2] <= 56'(s0_mag[47:24]) * 56'(INVLN2_Q63[31:0]);
            s1_pp[3] <= 56'(s0_mag[47:24]) * 56'(INVLN2_Q63[63:32]);
            // range checks, full quotient product
            s2_raw  <= s1_raw;
            s2_neg  <= s1_neg;
            if (!s1_neg && (64'(s1_mag) > lmax_c))
                s2_st <= ST_OVF;
            else if (s1_neg && (64'(s1_mag) > lmin_c))
                s2_st <= ST_ZERO;
            else
                s2_st <= ST_OK;
            s2_prod <= 112'(s1_pp[0]) + (112'(s1_pp[1]) << 32)
                     + (112'(s1_pp[2]) << 24) + (112'(s1_pp[3]) << 56);
            // round k, scale x to q62
            s3_neg  <= s2_neg;
            s3_st   <= s2_st;
            s3_kmag <= 16'(kround_c >> (FRAC_BITS - 1));
            s3_base <= {{(64 - ARG_W){s2_raw[ARG_W-1]}}, s2_raw} << (62 - FRAC_BITS);
            // k * ln2 partials, signed exponent
            s4_neg  <= s3_neg;
            s4_st   <= s3_st;
            s4_base <= s3_base;
            s4_ktl  <= 48'(s3_kmag) * 48'(LN2_Q62[31:0]);
            s4_kth  <= 48'(s3_kmag) * 48'(LN2_Q62[63:32]);
            if (s3_st != ST_OK)
                s4_expo <= '0;
            else if (s3_neg)
                s4_expo <= EXP_W'(16'd0 - s3_kmag);
            else
                s4_expo <= EXP_W'(s3_kmag);
            // k * ln2
            s5_neg   <= s4_neg;
            s5_st    <= s4_st;
            s5_expo  <= s4_expo;
            s5_base  <= s4_base;
            s5_kterm <= kterm_c;
            // remainder r
            s6_st   <= s5_st;
            s6_expo <= s5_expo;
            s6_rraw <= s5_neg ? (s5_base + s5_kterm) : (s5_base - s5_kterm);
            // sign and magnitude of r
            s7_st   <= s6_st;
            s7_expo <= s6_expo;
            s7_rneg <= s6_rraw[63];
            s7_rmag <= s6_rraw[63] ? 62'(64'd0 - s6_rraw) : s6_rraw[61:0];
        end
    end

    // series start: sum = term = 1.0
    always_comb
    begin
        t_init      = '0;
        t_init.sum  = 64'd1 << 62;
        t_init.tm   = 63'd1 << 62;
        t_init.rmag = s7_rmag;
        t_init.rneg = s7_rneg;
        t_init.expo = s7_expo;
        t_init.st   = s7_st;
    end

    // four stages per term: term*r, sum, times 1/i, quotient; last stage adds the final term
    for (genvar g = 0; g < NT; g++)
    begin : g_term
        localparam int unsigned TI  = g / 4 + 1;
        localparam int unsigned PH  = g % 4;
        localparam logic        ODD = 1'((TI - 1) % 2);
        term_t prev;

        if (g == 0)
        begin : g_first
            assign prev = t_init;
        end
        else
        begin : g_chain
            assign prev = tp_reg[g-1];
        end

        if (g == NT - 1)
        begin : g_last
            assign tp_next[g] = f_acc(prev, ODD);
        end
        else if (PH == 0)
        begin : g_mul_r
            if (TI == 1)
            begin : g_one
                assign tp_next[g] = f_mul_r(prev);
            end
            else
            begin : g_acc
                assign tp_next[g] = f_mul_r(f_acc(prev, ODD));
            end
        end
        else if (PH == 1)
        begin : g_sum_r
            assign tp_next[g] = f_sum_r(prev);
        end
        else if (PH == 2)
        begin : g_mul_m
            localparam int unsigned LG = $clog2(TI);
            localparam logic [127:0] MW =
                ((128'd1 << (63 + LG)) + 128'(TI) - 128'd1) / 128'(TI);
            assign tp_next[g] = f_mul_m(prev, MW[63:0]);
        end
        else
        begin : g_quot
            localparam int unsigned LG = $clog2(TI);
            assign tp_next[g] = f_quot(prev, 63 + LG);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NT; s++)
            begin
                tp_reg[s] <= tp_next[s];
            end
        end
    end

    // final rounding to the output format
    assign rnd_c = tp_reg[NT-1].sum + (64'd1 << (61 - FRAC_BITS));
    always_comb
    begin
        res_d = '0;
        res_d[MANT_W+EXP_W-1:MANT_W] = tp_reg[NT-1].expo;
        if (tp_reg[NT-1].st == ST_OK)
            res_d[MANT_W-1:0] = MANT_W'(rnd_c >> (62 - FRAC_BITS));
    end

    assign push     = en && v_reg[NS-1];
    assign out_take = out_v_reg && m_axis_tready;

    // output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_take)
                skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_v_reg && !out_take)
                skid_v_reg <= 1'b1;
            out_v_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_v_reg <= 1'b0;
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_take)
            begin
                out_d_reg <= skid_d_reg;
                out_u_reg <= skid_u_reg;
            end
        end
        else if (push)
        begin
            if (out_v_reg && !out_take)
            begin
                skid_d_reg <= res_d;
                skid_u_reg <= tp_reg[NT-1].st;
            end
            else
            begin
                out_d_reg <= res_d;
                out_u_reg <= tp_reg[NT-1].st;
            end
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;
    assign m_axis_tuser  = out_u_reg;

endmodule

// File: sv/erat_checker.sv
// port-level checks of the exponential unit and their binding
`include "exp_range_reduced_taylor_unit_defines.svh"

module erat_checker
    import erat_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // overflow and flush results carry zero mantissa and exponent
    `ERAT_ASSERT(a_special_zero, m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[48:0] == 49'd0), "special result with nonzero data")

    // input only stalls when a result is waiting
    `ERAT_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid, "input stalled with empty output")

    // a stalled result holds
    `ERAT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // no result during reset
    `ERAT_ASSERT_RST(a_rst_idle, !rst_n |-> !m_axis_tvalid, "result valid in reset")

endmodule

bind exp_range_reduced_taylor_unit erat_checker u_erat_checker (.*);

// File: tb/exp_checker.sv
// checker for the range-reduced exponential unit: predicts each result and compares it
module exp_checker
    import erat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [ARG_W-1:0]   s_axis_tdata,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [55:0]        m_axis_tdata,
    input  logic [1:0]         m_axis_tuser,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [SCALE_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [MANT_W-1:0] mant;
        logic [EXP_W-1:0]  expo;
        status_t           st;
    } exp_result_t;

    exp_result_t          result_fifo[$];
    logic [SCALE_W-1:0]   scale_reg;

    // floor(scale * ln2 * 2^32)
    function automatic logic [63:0] arg_limit(input logic [63:0] scale);
        logic [127:0] prod;
        prod = scale * {64'd0, LN2_Q64};
        return prod[95:32];
    endfunction

    // e^x by range reduction and truncated series
    function automatic exp_result_t exp_predict(input logic [ARG_W-1:0] arg,
                                                 input logic [SCALE_W-1:0] scale);
        exp_result_t  res;
        logic         neg, rneg, tneg;
        logic [63:0]  raw, mag, kmag, kterm, rraw, rmag, tm, sum;
        logic [127:0] prod;
        res  = '0;
        neg  = arg[ARG_W-1];
        raw  = {{16{neg}}, arg};
        mag  = neg ? -raw : raw;
        res.st = ST_OK;
        if (!neg && mag > arg_limit({50'd0, scale})) begin
            res.st = ST_OVF;
            return res;
        end
        if (neg && mag > arg_limit({49'd0, scale, 1'b0})) begin
            res.st = ST_ZERO;
            return res;
        end
        prod  = mag * {64'd0, INVLN2_Q63};
        kmag  = ((prod >> 64) + 128'd1073741824) >> 31;
        kterm = kmag * LN2_Q62;
        if (neg)
            kterm = -kterm;
        rraw = (raw << 30) - kterm;
        rneg = rraw[63];
        rmag = rneg ? -rraw : rraw;
        tm   = 64'd1 << 62;
        tneg = 1'b0;
        sum  = tm;
        for (int i = 1; i < 16; i++) begin
            prod = tm * {64'd0, rmag};
            tm   = prod[125:62] / i;
            tneg = tneg ^ rneg;
            sum  = tneg ? sum - tm : sum + tm;
        end
        sum      = (sum + (64'd1 << 29)) >> 30;
        res.mant = sum[MANT_W-1:0];
        kmag     = neg ? -kmag : kmag;
        res.expo = kmag[EXP_W-1:0];
        return res;
    endfunction

    assign pending = result_fifo.size();

    // track config, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        exp_result_t exp_r;
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RST;
            fail_count <= 0;
            result_fifo.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                scale_reg <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                result_fifo.push_back(exp_predict(s_axis_tdata, scale_reg));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_fifo.size() == 0)
                begin
                    $error("unexpected result: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = result_fifo.pop_front();
                    if (m_axis_tdata[32:0] !== exp_r.mant || m_axis_tdata[48:33] !== exp_r.expo
                        || m_axis_tuser !== exp_r.st || m_axis_tdata[55:49] !== 7'd0)
                        fail_count <= fail_count + 1;
                    if (m_axis_tdata[32:0] !== exp_r.mant)
                        $error("mantissa expected %h actual %h", exp_r.mant, m_axis_tdata[32:0]);
                    if (m_axis_tdata[48:33] !== exp_r.expo)
                        $error("exponent expected %h actual %h", exp_r.expo,
                               m_axis_tdata[48:33]);
                    if (m_axis_tuser !== exp_r.st)
                        $error("status expected %0d actual %0d", exp_r.st, m_axis_tuser);
                    if (m_axis_tdata[55:49] !== 7'd0)
                        $error("pad expected 0 actual %h", m_axis_tdata[55:49]);
                end
            end
        end
    end

endmodule

// File: tb/testbench.sv
// stimulus and verdict for the range-reduced exponential unit
module testbench;
    import erat_pkg::*;

    localparam int LATENCY   = 70;
    localparam int WDOG_MAX  = 20000;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [ARG_W-1:0]   s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [55:0]        m_axis_tdata;   // [32:0] mantissa, [48:33] exponent, [55:49] zero
    logic [1:0]         m_axis_tuser;   // [1:0] status
    logic               cfg_valid;
    logic               cfg_ready;
    logic [SCALE_W-1:0] cfg_data;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 wdog;
    logic [SCALE_W-1:0] cur_scale;

    exp_range_reduced_taylor_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    exp_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // send one argument request, idling at random first
    // valid stays up after the handshake until the next send or a drain
    task automatic send_arg(input logic [ARG_W-1:0] arg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= arg;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // drop the request, wait until all results are back and the pipe is empty
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // write max_scale while idle
    task automatic write_scale(input logic [SCALE_W-1:0] scale);
        drain_pipe();
        cfg_valid <= 1'b1;
        cfg_data  <= scale;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_scale = scale;
    endtask

    // random argument, biased around the limits and small values
    function automatic logic [ARG_W-1:0] rand_arg(input logic [SCALE_W-1:0] scale);
        logic [63:0] lim;
        logic [63:0] v;
        lim = ({50'd0, scale} * 64'd2977044472) + 64'd0;
        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = {32'd0, $urandom} >> $urandom_range(31);
            2: v = lim + $urandom_range(8) - 4;
            3: v = -(2 * lim + $urandom_range(8) - 4);
            4: v = -({32'd0, $urandom} >> $urandom_range(31));
            default: v = {$urandom, $urandom} >> $urandom_range(47);
        endcase
        return v[ARG_W-1:0];
    endfunction

    // run a random phase
    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            case ((i * 4) / count)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            send_arg(rand_arg(cur_scale));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b1;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_scale      = SCALE_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed extremes with the reset limit
        send_arg(48'h0);
        send_arg(48'h7FFF_FFFF_FFFF);
        send_arg(48'h8000_0000_0000);
        send_arg(48'hFFFF_FFFF_FFFF);
        send_arg(48'h0000_0000_0001);
        send_arg(48'h0000_8000_0000);
        send_arg(48'hFFFF_8000_0000);
        send_arg(48'h0000_B172_17F7);
        send_arg(48'h0000_58B9_0BFC);
        send_arg(48'hFFFF_A746_F404);
        send_arg(48'h2C5C_0000_0000);
        send_arg(48'hA747_0000_0000);

        // smallest and intermediate limits
        write_scale(14'd1);
        send_arg(48'h0000_B172_17F7);
        send_arg(48'h0000_B172_17F8);
        send_arg(48'hFFFE_9D1B_D012);
        send_arg(48'hFFFE_9D1B_D011);
        write_scale(14'd0);
        send_arg(48'h0);
        send_arg(48'h1);
        send_arg(48'hFFFF_FFFF_FFFF);

        write_scale(14'd1);
        random_phase(300);
        write_scale(14'd20);
        random_phase(300);
        write_scale(14'd16383);
        random_phase(400);
        // let every result come back before going on
        drain_pipe();
        write_scale(14'($urandom_range(16383, 1)));
        random_phase(300);
        write_scale(14'd8191);
        random_phase(300);

        // end of run
        recv_stall_pct = 0;
        drain_pipe();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
